// ===== hdl/sef_pkg.sv =====
`default_nettype none

package sef_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'h80;
  localparam logic [7:0] END_BYTE   = 8'h81;
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] START_SUB  = 8'hE7;
  localparam logic [7:0] END_SUB    = 8'hE8;
  localparam logic [7:0] ESC_SUB    = 8'h00;
  localparam logic [6:0] SUM_MASK   = 7'h7F;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // One classified request: what the back part has to send for one payload byte
  typedef struct packed {
    logic       start;  // open a frame before the data
    logic [7:0] data;   // payload byte
    logic       last;   // close the frame after the data
    logic [6:0] sum;    // checksum including this byte, valid when last
  } desc_t;

  // Head of the queue as seen by the back part
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } head_t;

  // Back part sequencing, one-hot
  typedef enum logic [5:0] {
    PH_HEAD     = 6'b000001,
    PH_DATA     = 6'b000010,
    PH_DATA_SUB = 6'b000100,
    PH_SUM      = 6'b001000,
    PH_SUM_SUB  = 6'b010000,
    PH_END      = 6'b100000
  } phase_t;

  // True for bytes that must be sent as an escape pair
  function automatic logic needs_escape(input logic [7:0] b);
    return (b == START_BYTE) || (b == END_BYTE) || (b == ESC_BYTE);
  endfunction

  // Second byte of an escape pair
  function automatic logic [7:0] escape_sub(input logic [7:0] b);
    logic [7:0] s;
    s = ESC_SUB;
    if (b == START_BYTE) begin
      s = START_SUB;
    end else if (b == END_BYTE) begin
      s = END_SUB;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sef_front.sv =====
`default_nettype none

module sef_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_data,
  input  wire logic          in_last,
  input  wire logic          queue_full,
  output logic               in_ready,
  output logic               push,
  output sef_pkg::desc_t     push_desc
);

  logic       in_frame;
  logic [6:0] running_xor;
  logic [6:0] sum_next;

  // Accept whenever the queue has room
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign sum_next = (running_xor ^ in_data[6:0]) & sef_pkg::SUM_MASK;

  // Classify the request
  always_comb begin
    push_desc.start = !in_frame;
    push_desc.data  = in_data;
    push_desc.last  = in_last;
    push_desc.sum   = sum_next;
  end

  // Track the open frame and its checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      running_xor <= '0;
    end else if (push) begin
      if (in_last) begin
        in_frame    <= 1'b0;
        running_xor <= '0;
      end else begin
        in_frame    <= 1'b1;
        running_xor <= sum_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sef_queue.sv =====
`default_nettype none

module sef_queue #(
  parameter int DEPTH = sef_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sef_pkg::desc_t push_desc,
  input  wire logic           pop,
  output logic                full,
  output sef_pkg::head_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sef_pkg::desc_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.desc  = mem[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sef_back.sv =====
`default_nettype none

module sef_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sef_pkg::head_t head,
  output logic                pop,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_burst,
  output logic                out_frame,
  input  wire logic           out_ready
);

  sef_pkg::phase_t phase;
  sef_pkg::phase_t cur;
  sef_pkg::phase_t phase_next;
  logic [7:0]      byte_next;
  logic [7:0]      sum_byte;
  logic            done;
  logic            frame_next;
  logic            load;

  assign sum_byte = {1'b0, head.desc.sum};
  assign load     = head.valid && (!out_valid || out_ready);
  assign pop      = load && done;

  // Pick the byte for the current step of the request
  always_comb begin
    cur = phase;
    if (phase == sef_pkg::PH_HEAD && !head.desc.start) begin
      cur = sef_pkg::PH_DATA;
    end
    byte_next  = head.desc.data;
    phase_next = phase;
    done       = 1'b0;
    frame_next = 1'b0;
    unique case (cur)
      sef_pkg::PH_HEAD: begin
        byte_next  = sef_pkg::START_BYTE;
        phase_next = sef_pkg::PH_DATA;
      end
      sef_pkg::PH_DATA: begin
        if (sef_pkg::needs_escape(head.desc.data)) begin
          byte_next  = sef_pkg::ESC_BYTE;
          phase_next = sef_pkg::PH_DATA_SUB;
        end else begin
          byte_next = head.desc.data;
          if (head.desc.last) begin
            phase_next = sef_pkg::PH_SUM;
          end else begin
            done = 1'b1;
          end
        end
      end
      sef_pkg::PH_DATA_SUB: begin
        byte_next = sef_pkg::escape_sub(head.desc.data);
        if (head.desc.last) begin
          phase_next = sef_pkg::PH_SUM;
        end else begin
          done = 1'b1;
        end
      end
      sef_pkg::PH_SUM: begin
        if (sef_pkg::needs_escape(sum_byte)) begin
          byte_next  = sef_pkg::ESC_BYTE;
          phase_next = sef_pkg::PH_SUM_SUB;
        end else begin
          byte_next  = sum_byte;
          phase_next = sef_pkg::PH_END;
        end
      end
      sef_pkg::PH_SUM_SUB: begin
        byte_next  = sef_pkg::escape_sub(sum_byte);
        phase_next = sef_pkg::PH_END;
      end
      sef_pkg::PH_END: begin
        byte_next  = sef_pkg::END_BYTE;
        frame_next = 1'b1;
        done       = 1'b1;
      end
      default: begin
        byte_next  = head.desc.data;
        phase_next = sef_pkg::PH_HEAD;
      end
    endcase
    if (done) begin
      phase_next = sef_pkg::PH_HEAD;
    end
  end

  // Step through the request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sef_pkg::PH_HEAD;
    end else if (load) begin
      phase <= phase_next;
    end
  end

  // Hold the output byte until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_next;
      out_burst <= done;
      out_frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stx_etx_frame_encoder.sv =====
`default_nettype none

// Byte-stuffing frame encoder. Each payload byte arrives with a last-of-frame
// flag; the first byte of a frame is preceded by 0x80, bytes 0x80, 0x81 and
// 0x1B are sent as 0x1B followed by 0xE7, 0xE8 or 0x00, and after the last
// byte the 7-bit XOR checksum of the frame (escaped the same way) and the end
// byte 0x81 follow. The input side takes one byte per cycle while the request
// queue (QUEUE_DEPTH entries) has room; the output side sends one byte per
// cycle while m_tready is high; a payload byte produces 1 output byte when
// plain, 2 when escaped, plus 1 for a frame start and 2 to 3 for a frame
// close, 6 at most. Sustained throughput is therefore set by the output
// sequencer at one output byte per cycle while m_tready is high. m_tlast marks
// the last output byte caused by an input byte; m_tuser marks the closing 0x81.

module stx_etx_frame_encoder #(
  parameter int QUEUE_DEPTH = sef_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // burst_end
  output logic            m_tuser    // [0] frame_end
);

  logic           push;
  sef_pkg::desc_t push_desc;
  logic           pop;
  logic           full;
  sef_pkg::head_t head;

  sef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_data    (s_tdata),
    .in_last    (s_tlast),
    .queue_full (full),
    .in_ready   (s_tready),
    .push       (push),
    .push_desc  (push_desc)
  );

  sef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  sef_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_byte  (m_tdata),
    .out_burst (m_tlast),
    .out_frame (m_tuser),
    .out_ready (m_tready)
  );

endmodule

`default_nettype wire
